@@ sv/b64e_pkg.sv @@
// Package for the base64 stream encoder: word types, the command word passed
// from the front end to the back end, and the sextet-to-character mapping.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package b64e_pkg;

  localparam int unsigned CharWidth       = 7;
  localparam int unsigned CharsPerCmd     = 4;
  localparam int unsigned CmdQueueDepth   = 2;
  localparam logic [CharWidth-1:0] PadChar = 7'd61;

  // Input word: one raw byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  // Output word: one character and the final-character flag.
  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 final_char;
  } out_word_t;

  // Everything one input byte produces: up to four characters, how many of
  // them are used (less one), and whether the last of them ends a message.
  typedef struct packed {
    logic [CharsPerCmd-1:0][CharWidth-1:0] chars;
    logic [1:0]                            num_m1;
    logic                                  last;
  } cmd_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharWidth-1:0] sextet_char(input logic [5:0] v);
    logic [CharWidth-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/b64e_front.sv @@
// Front end of the base64 stream encoder: accepts input bytes, keeps the
// group phase and carried bits, and builds one command word per byte.
// Depends on b64e_pkg.
`default_nettype none

module b64e_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire b64e_pkg::in_word_t item,
  output b64e_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] carry, carry_next;

  logic [7:0] b;
  logic       last;

  assign b    = item.data_byte;
  assign last = item.end_of_message;

  always_comb begin
    cmd.chars  = '{default: b64e_pkg::PadChar};
    cmd.num_m1 = 2'd0;
    cmd.last   = last;
    phase_next = phase;
    carry_next = carry;
    unique case (phase)
      PH_SECOND: begin
        cmd.chars[0] = b64e_pkg::sextet_char({carry[1:0], b[7:4]});
        cmd.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
        cmd.num_m1   = last ? 2'd2 : 2'd0;
        phase_next   = PH_THIRD;
        carry_next   = b[3:0];
      end
      PH_THIRD: begin
        cmd.chars[0] = b64e_pkg::sextet_char({carry, b[7:6]});
        cmd.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        cmd.num_m1   = 2'd1;
        phase_next   = PH_FIRST;
        carry_next   = 4'd0;
      end
      default: begin
        // The unused phase code behaves as the first byte of a group.
        cmd.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        cmd.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
        cmd.num_m1   = last ? 2'd3 : 2'd0;
        phase_next   = PH_SECOND;
        carry_next   = {2'b00, b[1:0]};
      end
    endcase
    if (last) begin
      phase_next = PH_FIRST;
      carry_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/b64e_queue.sv @@
// Short command queue between the front and back ends of the encoder.
// Register storage with a combinational head read. Depends on b64e_pkg.
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::CmdQueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64e_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output b64e_pkg::cmd_t       head,
  output logic                 head_valid
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  b64e_pkg::cmd_t store [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/b64e_back.sv @@
// Back end of the encoder: walks through the characters of the command at
// the queue head and presents them from an output register, one per cycle
// while the output is popped. Depends on b64e_pkg.
`default_nettype none

module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64e_pkg::cmd_t  head,
  input  wire logic            head_valid,
  output logic                 head_pop,
  output b64e_pkg::out_word_t  result,
  output logic                 empty,
  input  wire logic            pop
);

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       at_end;

  assign empty    = !out_valid;
  assign load     = head_valid && (!out_valid || pop);
  assign at_end   = (idx == head.num_m1);
  assign head_pop = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.char_code  <= head.chars[idx];
      result.final_char <= head.last && at_end;
    end
  end

endmodule

`default_nettype wire

@@ sv/base64_stream_encoder_core.sv @@
// Streaming base64 encoder (standard alphabet, '=' padding). Each input word
// carries one message byte and an end-of-message flag; each output word
// carries one ASCII character and a flag on the last character of a message.
// An input word is taken whenever the command queue has room: the front end
// turns it at once into a command holding every character the byte
// produces. The back end then emits one character per cycle while the
// output is popped, so the sustained rate is set by the output port: four
// characters per three bytes in the body of a message, and two to four
// characters for the final byte depending on where it falls in its group.
// The queue of QUEUE_DEPTH commands lets the front end keep accepting while
// the back end is still draining earlier bytes. A byte's first character
// reaches the output through the queue storage and then the output register.
`default_nettype none

module base64_stream_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::CmdQueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire b64e_pkg::in_word_t  item,
  output logic                     empty,
  input  wire logic                pop,
  output b64e_pkg::out_word_t      result
);

  b64e_pkg::cmd_t cmd;
  b64e_pkg::cmd_t head;
  logic           accept;
  logic           head_valid;
  logic           head_pop;

  // A word is accepted exactly when it is pushed into a queue with room.
  assign accept = push && !full;

  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cmd    (cmd)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

`ifndef SYNTH
  // A final byte always flushes at least two characters.
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd.last |-> cmd.num_m1 != 2'd0)
    else $error("final byte produced a single character");

  // A byte that does not end a message produces one or two characters.
  assert property (@(posedge clk) disable iff (rst)
    accept && !cmd.last |-> (cmd.num_m1 == 2'd0 || cmd.num_m1 == 2'd1))
    else $error("mid-message byte produced too many characters");

  // The output register is empty in the first cycle after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("output not empty after reset");

  // The back end only takes a command off a non-empty queue.
  assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire
